FILE: rtl/mppd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Masked pixel pair difference metric package
// Widths, constants and shared types for the accumulating front end, the
// result queue and the dividing back end.
// ----------------------------------------------------------------------------
package mppd_pkg;

   localparam int PIXEL_WIDTH   = 8;
   localparam int SUM_WIDTH     = 29;
   localparam int DIFF_WIDTH    = PIXEL_WIDTH + 1;
   localparam int FRACTION_BITS = 16;
   localparam int DIST_WIDTH    = 16;
   // Divisor is weight_sum + 255 and needs one bit more than a sum.
   localparam int DIV_WIDTH     = SUM_WIDTH + 1;
   localparam int COUNT_WIDTH   = $clog2(FRACTION_BITS);
   localparam int QUEUE_DEPTH   = 2;
   localparam int QPTR_WIDTH    = $clog2(QUEUE_DEPTH);
   localparam int QCOUNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

   localparam logic [SUM_WIDTH-1:0]   SUM_MAX    = {SUM_WIDTH{1'b1}};
   localparam logic [DIFF_WIDTH-1:0]  FULL_SCALE = DIFF_WIDTH'(255);
   localparam logic [COUNT_WIDTH-1:0] LAST_STEP  = COUNT_WIDTH'(FRACTION_BITS - 1);

   // Finished sums of one image, handed from the front end to the divider.
   typedef struct packed {
      logic [SUM_WIDTH-1:0] diff;
      logic [SUM_WIDTH-1:0] weight;
   } sums_type;

   typedef enum logic [2:0] {
      DIV_IDLE   = 3'b001,
      DIV_RUN    = 3'b010,
      DIV_WRITE  = 3'b100
   } div_state_type;

endpackage
`default_nettype wire

FILE: rtl/mppd_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pixel pair accumulator
// Takes one pixel pair per cycle while push_ready is high, skips pairs with
// both alphas zero and keeps the saturating difference and weight sums. On
// the last pair it pushes its sums into the result queue and clears them.
// ----------------------------------------------------------------------------
module mppd_front
   import mppd_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   output      logic                   in_ready,
   input  wire logic [PIXEL_WIDTH-1:0] red_a,
   input  wire logic [PIXEL_WIDTH-1:0] green_a,
   input  wire logic [PIXEL_WIDTH-1:0] alpha_a,
   input  wire logic [PIXEL_WIDTH-1:0] red_b,
   input  wire logic [PIXEL_WIDTH-1:0] green_b,
   input  wire logic [PIXEL_WIDTH-1:0] alpha_b,
   input  wire logic                   last_pixel,
   output      logic                   push_valid,
   input  wire logic                   push_ready,
   output      sums_type               push_sums
);

   logic [SUM_WIDTH-1:0]   diff_sum_ff, diff_sum_in;
   logic [SUM_WIDTH-1:0]   weight_sum_ff, weight_sum_in;
   logic [PIXEL_WIDTH-1:0] red_delta, green_delta;
   logic [DIFF_WIDTH-1:0]  pair_diff, pair_weight;
   logic [SUM_WIDTH:0]     diff_wide, weight_wide;
   logic [SUM_WIDTH-1:0]   diff_next, weight_next;
   logic                   counted, accept;

   assign red_delta   = (red_a > red_b) ? red_a - red_b : red_b - red_a;
   assign green_delta = (green_a > green_b) ? green_a - green_b : green_b - green_a;
   assign pair_diff   = {1'b0, red_delta} + {1'b0, green_delta};
   assign pair_weight = (pair_diff > FULL_SCALE) ? pair_diff : FULL_SCALE;
   assign counted     = (alpha_a != '0) || (alpha_b != '0);

   assign diff_wide   = {1'b0, diff_sum_ff}
                      + {{(SUM_WIDTH + 1 - DIFF_WIDTH){1'b0}}, pair_diff};
   assign weight_wide = {1'b0, weight_sum_ff}
                      + {{(SUM_WIDTH + 1 - DIFF_WIDTH){1'b0}}, pair_weight};

   always_comb begin
      diff_next   = diff_sum_ff;
      weight_next = weight_sum_ff;
      if (counted) begin
         diff_next   = diff_wide[SUM_WIDTH] ? SUM_MAX : diff_wide[SUM_WIDTH-1:0];
         weight_next = weight_wide[SUM_WIDTH] ? SUM_MAX : weight_wide[SUM_WIDTH-1:0];
      end
   end

   // A full queue stalls the stream, so a last pair always finds room.
   assign in_ready         = push_ready;
   assign accept           = in_valid && in_ready;
   assign push_valid       = accept && last_pixel;
   assign push_sums.diff   = diff_next;
   assign push_sums.weight = weight_next;

   always_comb begin
      diff_sum_in   = diff_sum_ff;
      weight_sum_in = weight_sum_ff;
      if (accept) begin
         diff_sum_in   = last_pixel ? '0 : diff_next;
         weight_sum_in = last_pixel ? '0 : weight_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         diff_sum_ff   <= '0;
         weight_sum_ff <= '0;
      end else begin
         diff_sum_ff   <= diff_sum_in;
         weight_sum_ff <= weight_sum_in;
      end
   end

   // Each pair adds at most its weight to the difference sum.
   assert property (@(posedge clock) disable iff (reset) diff_sum_ff <= weight_sum_ff)
      else $error("difference sum exceeds weight sum");

endmodule
`default_nettype wire

FILE: rtl/mppd_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Result queue
// Short first-in first-out buffer of finished image sums between the
// accumulator and the divider.
// ----------------------------------------------------------------------------
module mppd_queue
   import mppd_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push_valid,
   output      logic     push_ready,
   input  wire sums_type push_sums,
   output      logic     pop_valid,
   input  wire logic     pop_ready,
   output      sums_type pop_sums
);

   sums_type                entry_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCOUNT_WIDTH-1:0] count_ff, count_in;
   logic                    push, pop;

   assign push_ready = (count_ff != QCOUNT_WIDTH'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_sums   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_sums;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
         count_ff <= QCOUNT_WIDTH'(QUEUE_DEPTH))
      else $error("result queue overflow");

endmodule
`default_nettype wire

FILE: rtl/mppd_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Fraction divider
// Restoring divider that forms diff / (weight + 255) one quotient bit per
// cycle and holds the result in an output register.
// ----------------------------------------------------------------------------
module mppd_divider
   import mppd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  job_valid,
   output      logic                  job_ready,
   input  wire sums_type              job_sums,
   output      logic                  out_valid,
   input  wire logic                  out_ready,
   output      logic [DIST_WIDTH-1:0] out_data
);

   div_state_type            state_ff, state_in;
   logic [DIV_WIDTH-1:0]     rem_ff, rem_in;
   logic [DIV_WIDTH-1:0]     div_ff, div_in;
   logic [DIST_WIDTH-1:0]    quo_ff, quo_in;
   logic [COUNT_WIDTH-1:0]   count_ff, count_in;
   logic                     out_valid_ff, out_valid_in;
   logic [DIST_WIDTH-1:0]    out_data_ff, out_data_in;
   logic [DIV_WIDTH:0]       shifted;
   logic                     fits;
   logic                     out_free;

   assign shifted   = {rem_ff, 1'b0};
   assign fits      = shifted >= {1'b0, div_ff};
   assign out_free  = !out_valid_ff || out_ready;
   assign job_ready = (state_ff == DIV_IDLE);
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   always_comb begin
      state_in     = state_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      quo_in       = quo_ff;
      count_in     = count_ff;
      out_data_in  = out_data_ff;
      out_valid_in = out_valid_ff && !out_ready;
      unique case (state_ff)
         DIV_IDLE: begin
            if (job_valid) begin
               rem_in   = {1'b0, job_sums.diff};
               div_in   = {1'b0, job_sums.weight}
                        + {{(DIV_WIDTH - DIFF_WIDTH){1'b0}}, FULL_SCALE};
               count_in = LAST_STEP;
               state_in = DIV_RUN;
            end
         end
         DIV_RUN: begin
            // The dividend stays below the divisor, so the quotient fits.
            rem_in   = fits ? DIV_WIDTH'(shifted - {1'b0, div_ff})
                            : shifted[DIV_WIDTH-1:0];
            quo_in   = {quo_ff[DIST_WIDTH-2:0], fits};
            count_in = count_ff - 1'b1;
            if (count_ff == '0) begin
               state_in = DIV_WRITE;
            end
         end
         DIV_WRITE: begin
            if (out_free) begin
               out_data_in  = quo_ff;
               out_valid_in = 1'b1;
               state_in     = DIV_IDLE;
            end
         end
         default: begin
            state_in = DIV_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= DIV_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      div_ff      <= div_in;
      quo_ff      <= quo_in;
      count_ff    <= count_in;
      out_data_ff <= out_data_in;
   end

   assert property (@(posedge clock) disable iff (reset)
         (state_ff == DIV_RUN) |-> (rem_ff < div_ff))
      else $error("partial remainder not below divisor");

   assert property (@(posedge clock) disable iff (reset)
         (state_ff == DIV_WRITE) && out_free |=> out_valid_ff && (state_ff == DIV_IDLE))
      else $error("finished quotient not handed to the output register");

endmodule
`default_nettype wire

FILE: rtl/masked_pixel_pair_difference_metric.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Masked pixel pair difference metric
// Compares two equally sized images pixel by pixel and reports one
// normalized difference per image.
// ----------------------------------------------------------------------------
// The block takes one pixel pair per cycle on the req_ channel while there
// is queue room. A pair whose two alpha bytes are both zero is ignored; any
// other pair adds d = |red_a - red_b| + |green_a - green_b| to a difference
// sum and max(255, d) to a weight sum, both saturating at 29 bits. The
// transaction with req_tlast high closes the image: its sums go into a
// two-entry queue and are cleared, and one rsp_ transaction later carries
// floor(diff * 2^16 / (weight + 255)), an unsigned 0.16 fraction. An image
// with no counted pair gives zero. The accumulator takes a pair every cycle
// while the queue has room; the divider retires one quotient bit per cycle,
// working through load, 16 quotient steps and write per image. Images at
// least as long as that back-end work stream without pause while rsp_tready
// is high; shorter ones fill the queue and req_tready then drops until the
// divider frees an entry. The result sits in an output register, so the
// divider starts the next image while a result still waits on rsp_tready.
// ----------------------------------------------------------------------------
module masked_pixel_pair_difference_metric
   import mppd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   // red_a [7:0], green_a [15:8], alpha_a [23:16],
   // red_b [31:24], green_b [39:32], alpha_b [47:40]
   input  wire logic [47:0] req_tdata,
   input  wire logic        req_tlast,   // last_pixel
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // distance [15:0]
   output      logic [15:0] rsp_tdata
);

   logic     push_valid, push_ready;
   sums_type push_sums;
   logic     job_valid, job_ready;
   sums_type job_sums;

   // Front end: per-pixel difference, masking and running sums.
   mppd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .red_a      (req_tdata[7:0]),
      .green_a    (req_tdata[15:8]),
      .alpha_a    (req_tdata[23:16]),
      .red_b      (req_tdata[31:24]),
      .green_b    (req_tdata[39:32]),
      .alpha_b    (req_tdata[47:40]),
      .last_pixel (req_tlast),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_sums  (push_sums)
   );

   // Finished image sums wait here so each side can stall on its own.
   mppd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_sums  (push_sums),
      .pop_valid  (job_valid),
      .pop_ready  (job_ready),
      .pop_sums   (job_sums)
   );

   // Back end: bit-serial division and the output register.
   mppd_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job_ready (job_ready),
      .job_sums  (job_sums),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata)
   );

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the masked pixel pair difference metric
// Streams images of pixel pairs into the block with random gaps and random
// back pressure. It keeps its own running sums to predict each image's
// distance, and it checks every result transaction against that prediction
// in order.
// ----------------------------------------------------------------------------
module tb_top;
   import mppd_pkg::*;

   localparam int TARGET_PAIRS = 1050;
   // Cycles with no accepted transaction on either side before the run is
   // called hung. Long gaps, long stalls and the divider together stay far
   // below this.
   localparam int HANG_LIMIT   = 3000;
   // Cycles to watch for stray results once every expected one has arrived.
   localparam int DRAIN_CYCLES = 60;

   // Field order matches req_tdata, so red_a ends up in the lowest byte.
   typedef struct packed {
      logic [7:0] alpha_b;
      logic [7:0] green_b;
      logic [7:0] red_b;
      logic [7:0] alpha_a;
      logic [7:0] green_a;
      logic [7:0] red_a;
   } pixel_pair_type;

   typedef struct packed {
      logic           last;
      pixel_pair_type pair;
   } pair_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;

   pair_beat_type            pending_pairs[$];
   logic [DIST_WIDTH-1:0]    expected_distances[$];
   logic [SUM_WIDTH-1:0]     diff_total = '0;
   logic [SUM_WIDTH-1:0]     weight_total = '0;
   int                       pairs_queued = 0;
   int                       mismatches = 0;
   int                       send_gap = 0;
   int                       recv_stall = 0;
   int                       idle_cycles = 0;
   bit                       send_steady = 1'b0;
   bit                       recv_steady = 1'b0;

   masked_pixel_pair_difference_metric dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Distance predictor
   // ------------------------------------------------------------------------

   function automatic logic [8:0] channel_gap(logic [7:0] x, logic [7:0] y);
      return (x > y) ? 9'(x - y) : 9'(y - x);
   endfunction

   function automatic logic [SUM_WIDTH-1:0] add_clamped(logic [SUM_WIDTH-1:0] total,
                                                         logic [9:0] amount);
      logic [SUM_WIDTH:0] wide;
      wide = {1'b0, total} + (SUM_WIDTH + 1)'(amount);
      return (wide > {1'b0, SUM_MAX}) ? SUM_MAX : wide[SUM_WIDTH-1:0];
   endfunction

   // Folds one accepted pair into the running sums. The pair that closes an
   // image yields the expected distance and clears the sums, even when the
   // pair itself is empty.
   task automatic account_pair(input pixel_pair_type pair, input logic last);
      logic [9:0]  d;
      logic [63:0] numerator;
      logic [63:0] divisor;
      logic [63:0] quotient;
      if (pair.alpha_a != 8'd0 || pair.alpha_b != 8'd0) begin
         d = 10'(channel_gap(pair.red_a, pair.red_b)) +
             10'(channel_gap(pair.green_a, pair.green_b));
         diff_total   = add_clamped(diff_total, d);
         weight_total = add_clamped(weight_total, (d > 10'(FULL_SCALE)) ? d : 10'(FULL_SCALE));
      end
      if (last) begin
         numerator = 64'(diff_total) << FRACTION_BITS;
         divisor   = 64'(weight_total) + 64'(FULL_SCALE);
         quotient  = numerator / divisor;
         if (quotient > 64'hFFFF) begin
            quotient = 64'hFFFF;
         end
         expected_distances = {expected_distances, quotient[DIST_WIDTH-1:0]};
         diff_total   = '0;
         weight_total = '0;
      end
   endtask

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------

   task automatic push_pair(input logic [7:0] red_a, input logic [7:0] green_a,
                            input logic [7:0] alpha_a, input logic [7:0] red_b,
                            input logic [7:0] green_b, input logic [7:0] alpha_b,
                            input logic last);
      pair_beat_type beat;
      beat.pair = '{alpha_b: alpha_b, green_b: green_b, red_b: red_b,
                    alpha_a: alpha_a, green_a: green_a, red_a: red_a};
      beat.last = last;
      pending_pairs = {pending_pairs, beat};
      pairs_queued++;
   endtask

   // Mostly arbitrary colors, with some near matches for small differences
   // and some inverted colors for large ones. About one pair in five is
   // empty, and some have only one alpha set.
   task automatic push_random_pair(input logic last);
      logic [7:0] ra, ga, rb, gb, aa, ab;
      int         style;
      int         coverage;
      ra = 8'($urandom);
      ga = 8'($urandom);
      rb = 8'($urandom);
      gb = 8'($urandom);
      aa = 8'($urandom);
      ab = 8'($urandom);
      style = $urandom_range(0, 9);
      if (style < 3) begin
         rb = ra + 8'($urandom_range(0, 6)) - 8'd3;
         gb = ga + 8'($urandom_range(0, 6)) - 8'd3;
      end else if (style == 3) begin
         rb = ~ra;
         gb = ~ga;
      end
      coverage = $urandom_range(0, 9);
      if (coverage < 2) begin
         aa = 8'd0;
         ab = 8'd0;
      end else if (coverage == 2) begin
         aa = 8'd0;
      end else if (coverage == 3) begin
         ab = 8'd0;
      end
      push_pair(ra, ga, aa, rb, gb, ab, last);
   endtask

   // Gap lengths: mostly none or short, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(6, 40);
   endfunction

   initial begin
      int length;
      int pick;

      // An image with nothing but one empty pair gives zero.
      push_pair(8'd10, 8'd20, 8'd0, 8'd200, 8'd100, 8'd0, 1'b1);
      // Only one alpha set still counts the pair, on either side.
      push_pair(8'd0, 8'd0, 8'd0, 8'd40, 8'd60, 8'd1, 1'b1);
      push_pair(8'd90, 8'd5, 8'd255, 8'd80, 8'd15, 8'd0, 1'b1);
      // Largest difference in a single pair.
      push_pair(8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd255, 1'b1);
      // Identical pixels, all ones and all zeros in the colors.
      push_pair(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
      push_pair(8'd0, 8'd0, 8'd128, 8'd0, 8'd0, 8'd1, 1'b1);
      // Weight equals the difference exactly at 255, and just above it.
      push_pair(8'd255, 8'd7, 8'd3, 8'd0, 8'd7, 8'd3, 1'b1);
      push_pair(8'd255, 8'd8, 8'd3, 8'd0, 8'd7, 8'd3, 1'b1);
      // A counted pair followed by an empty closing pair.
      push_pair(8'd30, 8'd200, 8'd9, 8'd130, 8'd50, 8'd9, 1'b0);
      push_pair(8'd1, 8'd2, 8'd0, 8'd3, 8'd4, 8'd0, 1'b1);
      // A run of maximum differences pushes the distance toward its top.
      for (int i = 0; i < 8; i++) begin
         push_pair(8'd0, 8'd255, 8'd255, 8'd255, 8'd0, 8'd255, 1'(i == 7));
      end

      // Random images, most of them short enough to fill the divider queue.
      while (pairs_queued < TARGET_PAIRS) begin
         pick = $urandom_range(0, 9);
         if (pick < 6) begin
            length = $urandom_range(1, 20);
         end else if (pick < 9) begin
            length = $urandom_range(21, 60);
         end else begin
            length = $urandom_range(61, 150);
         end
         for (int i = 0; i < length; i++) begin
            push_random_pair(1'(i == length - 1));
         end
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Wait until every pair has been taken, then until every distance has
      // come back, and then watch a little longer for stray results.
      while (pending_pairs.size() != 0 || req_tvalid) begin
         @(posedge clock);
      end
      while (expected_distances.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // ------------------------------------------------------------------------
   // Request driver
   // ------------------------------------------------------------------------
   // A transaction completes at an edge where req_tvalid and req_tready were
   // both high; the pair is handed to the predictor at that edge. A new pair
   // goes out only once the previous one is gone, after its random gap.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap   <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            account_pair(pixel_pair_type'(req_tdata), req_tlast);
         end
         if ($urandom_range(0, 63) == 0) begin
            send_steady <= ~send_steady;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap != 0 || pending_pairs.size() == 0) begin
               req_tvalid <= 1'b0;
               if (send_gap != 0) begin
                  send_gap <= send_gap - 1;
               end
            end else begin
               req_tdata  <= pending_pairs[0].pair;
               req_tlast  <= pending_pairs[0].last;
               req_tvalid <= 1'b1;
               void'(pending_pairs.pop_front());
               send_gap   <= send_steady ? 0 : pick_gap();
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Result side: back pressure and checking
   // ------------------------------------------------------------------------
   // Stalls start at random; in steady stretches no new stall starts.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_stall <= 0;
      end else begin
         if ($urandom_range(0, 199) == 0) begin
            recv_steady <= ~recv_steady;
         end
         if (recv_stall != 0) begin
            rsp_tready <= 1'b0;
            recv_stall <= recv_stall - 1;
         end else begin
            rsp_tready <= 1'b1;
            if (!recv_steady && $urandom_range(0, 9) == 0) begin
               recv_stall <= pick_gap();
            end
         end
      end
   end

   // Every result transaction must match the oldest outstanding distance.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_distances.size() == 0) begin
            $error("distance: unexpected result, actual %0d", rsp_tdata);
            mismatches++;
         end else begin
            if (rsp_tdata !== expected_distances[0]) begin
               $error("distance mismatch: expected %0d, actual %0d",
                      expected_distances[0], rsp_tdata);
               mismatches++;
            end
            void'(expected_distances.pop_front());
         end
      end
   end

   // The run is hung if neither side completes a transaction for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= HANG_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
